>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sort and merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

>>> hdl/sam_pkg.sv
// Types and codes shared by the sort and merge cell chain and its control.
package sam_pkg;

   localparam int ValueWidth  = 32;
   localparam int ActionWidth = 2;

   // Input action codes
   localparam logic [ActionWidth-1:0] ActAppendFirst  = 2'd0;
   localparam logic [ActionWidth-1:0] ActAppendSecond = 2'd1;
   localparam logic [ActionWidth-1:0] ActEmit         = 2'd2;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

   // Control states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

>>> hdl/sort_and_merge_two_lists.sv
// Top level: append control, cell chain and result register of the merge sorter.
//
// Appends are taken one per cycle while not busy and go straight into their
// sorted place in a chain of 2*MAX_LEN cells, so both lists are kept merged
// and ordered at all times; per-list counts drop appends to a full list. A
// start with action 2 makes the block busy while the chain shifts toward its
// head one cell per cycle: N stored values give N result beats on consecutive
// cycles, the first after the state register and then the result register,
// and the block takes the next item in the cycle of the last beat. A start
// with both lists empty gives no beat and leaves the block idle. Results
// cannot be held off by the receiver; each beat is valid for one cycle while
// rsp_strobe is high. No clearing pass after reset is needed.
`include "assert_macros.svh"

module sort_and_merge_two_lists #(
   parameter int MAX_LEN = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [sam_pkg::ActionWidth-1:0]        req_action,
   input  logic signed [sam_pkg::ValueWidth-1:0]  req_value,
   output logic                                   rsp_strobe,
   output logic signed [sam_pkg::ValueWidth-1:0]  rsp_sorted_value,
   output logic                                   rsp_last
);

   localparam int Depth      = 2 * MAX_LEN;
   localparam int CountWidth = $clog2(MAX_LEN + 1);

   sam_pkg::state_type    state_ff, state_in;
   logic [CountWidth-1:0] first_count_ff, first_count_in;
   logic [CountWidth-1:0] second_count_ff, second_count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic signed [sam_pkg::ValueWidth-1:0] rsp_value_ff;
   logic                  rsp_last_ff;

   sam_pkg::cell_ctl_type ctl;
   logic                  accept;
   logic                  first_full, second_full;

   logic signed [sam_pkg::ValueWidth-1:0] cell_value [Depth];
   logic [Depth-1:0]      cell_valid;
   logic [Depth-1:0]      cell_gt;

   assign busy       = (state_ff == sam_pkg::ST_EMIT);
   assign accept     = start && !busy;
   assign first_full  = (first_count_ff == CountWidth'(MAX_LEN));
   assign second_full = (second_count_ff == CountWidth'(MAX_LEN));

   // Decode the accepted beat into a chain command and next counts
   always_comb begin
      ctl             = '0;
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      rsp_strobe_in   = 1'b0;
      unique case (state_ff)
         sam_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  sam_pkg::ActAppendFirst: begin
                     if (!first_full) begin
                        ctl.insert     = 1'b1;
                        first_count_in = first_count_ff + CountWidth'(1);
                     end
                  end
                  sam_pkg::ActAppendSecond: begin
                     if (!second_full) begin
                        ctl.insert      = 1'b1;
                        second_count_in = second_count_ff + CountWidth'(1);
                     end
                  end
                  sam_pkg::ActEmit: begin
                     first_count_in  = '0;
                     second_count_in = '0;
                     if (cell_valid[0]) begin
                        state_in = sam_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sam_pkg::ST_EMIT: begin
            // Pop the head cell every cycle until the chain runs dry
            ctl.shift     = 1'b1;
            rsp_strobe_in = 1'b1;
            if (!cell_valid[1]) begin
               state_in = sam_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sam_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sam_pkg::ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // Register the head cell as the outgoing beat
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         rsp_value_ff <= cell_value[0];
         rsp_last_ff  <= !cell_valid[1];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // Build the chain; the head sees no left neighbor, the tail no right one
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic                                  left_gt;
      logic signed [sam_pkg::ValueWidth-1:0] left_value;
      logic                                  left_valid;
      logic signed [sam_pkg::ValueWidth-1:0] right_value;
      logic                                  right_valid;

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_value = '0;
         assign left_valid = 1'b0;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == Depth - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      sam_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_value   (req_value),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   // A beat only follows a cycle spent emitting
   `ASSERT_IMPLY(a_strobe_after_emit, clock, reset, rsp_strobe, $past(busy))
   // The last flag only rides on a beat
   `ASSERT_IMPLY(a_last_on_beat, clock, reset, rsp_last && rsp_strobe_ff, rsp_strobe)
   // Occupied cells match the two list counts while idle
   `ASSERT_IMPLY(a_count_match, clock, reset, !busy,
      $countones(cell_valid) == (int'(first_count_ff) + int'(second_count_ff)))
   // Counts never pass the list capacity
   `ASSERT_ALWAYS(a_count_bound, clock, reset,
      (int'(first_count_ff) <= MAX_LEN) && (int'(second_count_ff) <= MAX_LEN))

endmodule

>>> hdl/sam_cell.sv
// One cell of the sorted chain: holds one value and its valid bit.
module sam_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  sam_pkg::cell_ctl_type               ctl,
   input  logic signed [sam_pkg::ValueWidth-1:0] new_value,
   input  logic                                left_gt,
   input  logic signed [sam_pkg::ValueWidth-1:0] left_value,
   input  logic                                left_valid,
   input  logic signed [sam_pkg::ValueWidth-1:0] right_value,
   input  logic                                right_valid,
   output logic signed [sam_pkg::ValueWidth-1:0] value,
   output logic                                valid,
   output logic                                gt
);

   logic signed [sam_pkg::ValueWidth-1:0] value_ff, value_in;
   logic                                  valid_ff, valid_in;

   // An empty cell counts as greater than any new value
   assign gt = !valid_ff || (value_ff > new_value);

   // Insert: move right of the insertion point, take new value at it
   // Shift: take the right neighbor's contents toward the head
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctl.insert && gt) begin
         if (left_gt) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule
